@@ rtl/fdc_pkg.sv @@
package fdc_pkg;

    localparam int DEF_COORD_BITS = 21;
    localparam int FRAC_BITS      = 8;
    localparam int SQRT_STEPS     = 2;
    localparam int SCALE_W        = 24;
    localparam int SCALE_FRAC     = 28;
    localparam int DELAY_W        = 32;
    localparam int FOCAL_W        = 20;
    localparam int APER_W         = 20;
    localparam int RADIUS_W       = 21;
    localparam int MODE_W         = 3;
    localparam int CFG_IDX_W      = 3;

    localparam logic [MODE_W-1:0] MODE_NONE = 3'd0;
    localparam logic [MODE_W-1:0] MODE_X    = 3'd1;
    localparam logic [MODE_W-1:0] MODE_Y    = 3'd2;
    localparam logic [MODE_W-1:0] MODE_XY   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_SEP  = 3'd4;
    localparam logic [MODE_W-1:0] MODE_USER = 3'd5;

    localparam logic [CFG_IDX_W-1:0] REG_MODE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FOCAL  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_APER_X = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_APER_Y = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RADIUS = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE  = 3'd5;

    localparam logic [SCALE_W-1:0] SCALE_RST = 24'd699051;

    typedef struct packed {
        logic [MODE_W-1:0]   mode;
        logic [FOCAL_W-1:0]  focal;
        logic [APER_W-1:0]   aper_x;
        logic [APER_W-1:0]   aper_y;
        logic [RADIUS_W-1:0] radius;
        logic [SCALE_W-1:0]  scale;
    } cfg_t;

endpackage

@@ rtl/fdc_front.sv @@
module fdc_front #(
    parameter int COORD_BITS = 21,
    parameter int SQ_W       = 44
) (
    input  logic                         clk,
    input  logic [2:0]                   en,
    input  logic signed [COORD_BITS-1:0] elem_x,
    input  logic signed [COORD_BITS-1:0] elem_y,
    input  fdc_pkg::cfg_t                cfg,
    output logic [SQ_W-1:0]              sum_edge,
    output logic [SQ_W-1:0]              sum_main,
    output logic [SQ_W-1:0]              sum_y
);
    import fdc_pkg::*;

    logic [COORD_BITS-1:0]   mx_reg, my_reg, mx_next, my_next;
    logic [RADIUS_W-1:0]     edge_reg, edge_next;
    logic [2*COORD_BITS-1:0] x2_reg, y2_reg;
    logic [2*FOCAL_W-1:0]    f2_reg;
    logic [2*RADIUS_W-1:0]   e2_reg;
    logic [SQ_W-1:0]         sum_edge_reg, sum_main_reg, sum_y_reg;
    logic [SQ_W-1:0]         x2e, y2e, f2e, e2e;

    always_comb
    begin
        mx_next = elem_x[COORD_BITS-1] ? (~elem_x + 1'b1) : elem_x;
        my_next = elem_y[COORD_BITS-1] ? (~elem_y + 1'b1) : elem_y;
        case (cfg.mode)
            MODE_X:  edge_next = {1'b0, cfg.aper_x};
            MODE_Y:  edge_next = {1'b0, cfg.aper_y};
            default: edge_next = cfg.radius;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            mx_reg   <= mx_next;
            my_reg   <= my_next;
            edge_reg <= edge_next;
        end
        if (en[1])
        begin
            x2_reg <= mx_reg * mx_reg;
            y2_reg <= my_reg * my_reg;
            f2_reg <= cfg.focal * cfg.focal;
            e2_reg <= edge_reg * edge_reg;
        end
        if (en[2])
        begin
            sum_edge_reg <= e2e + f2e;
            sum_y_reg    <= y2e + f2e;
            case (cfg.mode)
                MODE_Y:  sum_main_reg <= y2e + f2e;
                MODE_XY: sum_main_reg <= x2e + y2e + f2e;
                default: sum_main_reg <= x2e + f2e;
            endcase
        end
    end

    assign x2e = SQ_W'(x2_reg);
    assign y2e = SQ_W'(y2_reg);
    assign f2e = SQ_W'(f2_reg);
    assign e2e = SQ_W'(e2_reg);

    assign sum_edge = sum_edge_reg;
    assign sum_main = sum_main_reg;
    assign sum_y    = sum_y_reg;

endmodule

@@ rtl/fdc_sqrt_pipe.sv @@
module fdc_sqrt_pipe #(
    parameter int SQ_W  = 44,
    parameter int NPAIR = 30,
    parameter int NSTG  = 15
) (
    input  logic             clk,
    input  logic [NSTG-1:0]  en,
    input  logic [SQ_W-1:0]  s,
    output logic [NPAIR-1:0] root
);
    import fdc_pkg::*;

    localparam int RW = NPAIR + 2;
    localparam int XW = 2 * NPAIR;

    logic [NPAIR-1:0] root_reg [NSTG];
    logic [RW-1:0]    rem_reg  [NSTG-1];
    logic [XW-1:0]    x_reg    [NSTG-1];

    for (genvar g = 0; g < NSTG; g++)
    begin : g_stg
        logic [RW-1:0]    rem_in, rem_next;
        logic [NPAIR-1:0] root_in, root_next;
        logic [XW-1:0]    x_in, x_next;

        if (g == 0)
        begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign x_in    = {s, {(XW-SQ_W){1'b0}}};
        end
        else
        begin : g_rest
            assign rem_in  = rem_reg[g-1];
            assign root_in = root_reg[g-1];
            assign x_in    = x_reg[g-1];
        end

        always_comb
        begin : p_step
            logic [RW-1:0] trial;
            rem_next  = rem_in;
            root_next = root_in;
            x_next    = x_in;
            trial     = '0;
            for (int t = 0; t < SQRT_STEPS; t++)
            begin
                if (g * SQRT_STEPS + t < NPAIR)
                begin
                    rem_next = {rem_next[NPAIR-1:0], x_next[XW-1 -: 2]};
                    x_next   = x_next << 2;
                    trial    = {root_next, 2'b01};
                    if (rem_next >= trial)
                    begin
                        rem_next  = rem_next - trial;
                        root_next = {root_next[NPAIR-2:0], 1'b1};
                    end
                    else
                    begin
                        root_next = {root_next[NPAIR-2:0], 1'b0};
                    end
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (en[g])
            begin
                root_reg[g] <= root_next;
            end
        end

        if (g < NSTG - 1)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                if (en[g])
                begin
                    rem_reg[g] <= rem_next;
                    x_reg[g]   <= x_next;
                end
            end
        end
    end

    assign root = root_reg[NSTG-1];

endmodule

@@ rtl/fdc_scale.sv @@
module fdc_scale #(
    parameter int ROOT_W = 30
) (
    input  logic                         clk,
    input  logic [3:0]                   en,
    input  logic [ROOT_W-1:0]            root_edge,
    input  logic [ROOT_W-1:0]            root_main,
    input  logic [ROOT_W-1:0]            root_y,
    input  fdc_pkg::cfg_t                cfg,
    output logic [fdc_pkg::DELAY_W-1:0]  delay
);
    import fdc_pkg::*;

    localparam int DM_W   = ROOT_W + 1;
    localparam int PROD_W = DM_W + SCALE_W;
    localparam int R_W    = PROD_W - SCALE_FRAC + 1;
    localparam int RX_W   = (R_W > DELAY_W + 1) ? R_W : DELAY_W + 1;

    logic [DM_W-1:0]      elem_path, mag_reg;
    logic                 neg1_reg, neg2_reg, neg3_reg;
    logic [2*SCALE_W-1:0] lo_reg;
    logic [DM_W-1:0]      hi_reg;
    logic [PROD_W:0]      total;
    logic [RX_W-1:0]      r_reg;
    logic [DELAY_W-1:0]   sat, delay_reg, delay_next;

    localparam logic [RX_W-1:0] POS_MAX = RX_W'(32'h7FFF_FFFF);
    localparam logic [RX_W-1:0] NEG_MAX = RX_W'(32'h8000_0000);

    assign elem_path = (cfg.mode == MODE_SEP) ? ({1'b0, root_main} + {1'b0, root_y})
                                              : {1'b0, root_main};

    assign total = (PROD_W+1)'({hi_reg, {SCALE_W{1'b0}}}) + (PROD_W+1)'(lo_reg)
                 + ((PROD_W+1)'(1) << (SCALE_FRAC - 1));

    always_comb
    begin
        if (!neg3_reg)
        begin
            sat = (r_reg > POS_MAX) ? DELAY_W'(32'h7FFF_FFFF) : r_reg[DELAY_W-1:0];
        end
        else
        begin
            sat = (r_reg > NEG_MAX) ? DELAY_W'(32'h8000_0000) : (~r_reg[DELAY_W-1:0] + 1'b1);
        end
        case (cfg.mode)
            MODE_X, MODE_Y, MODE_XY, MODE_SEP: delay_next = sat;
            MODE_USER:                         delay_next = DELAY_W'(cfg.focal);
            default:                           delay_next = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            neg1_reg <= elem_path > {1'b0, root_edge};
            mag_reg  <= (elem_path > {1'b0, root_edge}) ? elem_path - {1'b0, root_edge}
                                                        : {1'b0, root_edge} - elem_path;
        end
        if (en[1])
        begin
            neg2_reg <= neg1_reg;
            lo_reg   <= mag_reg[SCALE_W-1:0] * cfg.scale;
            hi_reg   <= DM_W'(mag_reg[DM_W-1:SCALE_W] * cfg.scale);
        end
        if (en[2])
        begin
            neg3_reg <= neg2_reg;
            r_reg    <= RX_W'(total[PROD_W:SCALE_FRAC]);
        end
        if (en[3])
        begin
            delay_reg <= delay_next;
        end
    end

    assign delay = delay_reg;

endmodule

@@ rtl/focusing_delay_calc.sv @@
// An accepted request passes through the front-end registers, the three parallel
// square root pipelines and the scale registers to its result.
// Throughput: one request per cycle unless out_ready backpressure stalls the pipeline.
// Empty stages load during stalls, so bubbles are absorbed before input backpressure.
// Reset clears all valid bits and the configuration registers; cfg scale resets to 699051.
module focusing_delay_calc
    import fdc_pkg::*;
#(
    parameter int COORD_BITS = fdc_pkg::DEF_COORD_BITS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic signed [COORD_BITS-1:0]    elem_x,
    input  logic signed [COORD_BITS-1:0]    elem_y,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic signed [fdc_pkg::DELAY_W-1:0] delay_ns,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [fdc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [31:0]                     cfg_data
);

    localparam int SQ_W  = (2 * COORD_BITS > 44) ? 2 * COORD_BITS : 44;
    localparam int NPAIR = SQ_W / 2 + FRAC_BITS;
    localparam int NSTG  = (NPAIR + SQRT_STEPS - 1) / SQRT_STEPS;
    localparam int NPIPE = NSTG + 7;
    localparam int SQ0   = 3;
    localparam int SC0   = SQ0 + NSTG;

    cfg_t             cfg_reg;
    logic [NPIPE-1:0] v_reg, v_next, en;
    logic [SQ_W-1:0]  sum_edge, sum_main, sum_y;
    logic [NPAIR-1:0] root_edge, root_main, root_y;
    logic [DELAY_W-1:0] delay;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode   <= MODE_NONE;
            cfg_reg.focal  <= '0;
            cfg_reg.aper_x <= '0;
            cfg_reg.aper_y <= '0;
            cfg_reg.radius <= '0;
            cfg_reg.scale  <= SCALE_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_MODE:   cfg_reg.mode   <= cfg_data[MODE_W-1:0];
                REG_FOCAL:  cfg_reg.focal  <= cfg_data[FOCAL_W-1:0];
                REG_APER_X: cfg_reg.aper_x <= cfg_data[APER_W-1:0];
                REG_APER_Y: cfg_reg.aper_y <= cfg_data[APER_W-1:0];
                REG_RADIUS: cfg_reg.radius <= cfg_data[RADIUS_W-1:0];
                REG_SCALE:  cfg_reg.scale  <= cfg_data[SCALE_W-1:0];
                default:    cfg_reg        <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        en[NPIPE-1] = !v_reg[NPIPE-1] || out_ready;
        for (int i = NPIPE - 2; i >= 0; i--)
        begin
            en[i] = !v_reg[i] || en[i+1];
        end
        for (int i = 0; i < NPIPE; i++)
        begin
            if (en[i])
            begin
                v_next[i] = (i == 0) ? in_valid : v_reg[(i == 0) ? 0 : i-1];
            end
            else
            begin
                v_next[i] = v_reg[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= v_next;
        end
    end

    fdc_front #(
        .COORD_BITS (COORD_BITS),
        .SQ_W       (SQ_W)
    ) u_front (
        .clk      (clk),
        .en       (en[2:0]),
        .elem_x   (elem_x),
        .elem_y   (elem_y),
        .cfg      (cfg_reg),
        .sum_edge (sum_edge),
        .sum_main (sum_main),
        .sum_y    (sum_y)
    );

    fdc_sqrt_pipe #(.SQ_W(SQ_W), .NPAIR(NPAIR), .NSTG(NSTG)) u_sqrt_edge (
        .clk  (clk),
        .en   (en[SQ0 +: NSTG]),
        .s    (sum_edge),
        .root (root_edge)
    );

    fdc_sqrt_pipe #(.SQ_W(SQ_W), .NPAIR(NPAIR), .NSTG(NSTG)) u_sqrt_main (
        .clk  (clk),
        .en   (en[SQ0 +: NSTG]),
        .s    (sum_main),
        .root (root_main)
    );

    fdc_sqrt_pipe #(.SQ_W(SQ_W), .NPAIR(NPAIR), .NSTG(NSTG)) u_sqrt_y (
        .clk  (clk),
        .en   (en[SQ0 +: NSTG]),
        .s    (sum_y),
        .root (root_y)
    );

    fdc_scale #(
        .ROOT_W (NPAIR)
    ) u_scale (
        .clk       (clk),
        .en        (en[SC0 +: 4]),
        .root_edge (root_edge),
        .root_main (root_main),
        .root_y    (root_y),
        .cfg       (cfg_reg),
        .delay     (delay)
    );

    assign in_ready  = en[0];
    assign out_valid = v_reg[NPIPE-1];
    assign delay_ns  = delay;

endmodule
